@@ rtl/core/nnis_pkg.sv @@
package nnis_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int PixelBits = 24;
  localparam int SizeBits  = 9;
  localparam int CoordBits = 8;
  localparam int FracBits  = 16;
  localparam int AccBits   = 24;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrBits  = $clog2(StoreDepth);
  localparam int DivBits   = SizeBits + FracBits;
  localparam int DivCntBits = $clog2(DivBits);
  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CfgSrcWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgSrcHeight = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgDstWidth  = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgDstHeight = 2'd3;

  localparam logic [SizeBits-1:0] MaxWidthSz  = SizeBits'(MaxWidth);
  localparam logic [SizeBits-1:0] MaxHeightSz = SizeBits'(MaxHeight);

  typedef struct packed {
    logic                 fetch;
    logic [PixelBits-1:0] pixel;
  } item_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StRead = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  function automatic logic [SizeBits-1:0] clamp_size(input logic [SizeBits-1:0] v,
                                                     input logic [SizeBits-1:0] maxv);
    logic [SizeBits-1:0] r;
    if (v == '0) begin
      r = SizeBits'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/nnis_ram.sv @@
module nnis_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536,
  localparam int AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/nnis_div.sv @@
module nnis_div
  import nnis_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SizeBits-1:0] src_i,
  input  logic [SizeBits-1:0] dst_i,
  output logic                done_o,
  output logic [AccBits-1:0]  step_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [DivBits-1:0]    num_q, num_d;
  logic [DivBits-1:0]    quo_q, quo_d;
  logic [SizeBits-1:0]   rem_q, rem_d;
  logic [SizeBits-1:0]   den_q, den_d;
  logic [SizeBits:0]     trial;
  logic                  qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, num_q[DivBits-1]};
    qbit   = trial >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntBits'(DivBits - 1);
      num_d  = {src_i, {FracBits{1'b0}}};
      rem_d  = '0;
      den_d  = dst_i;
    end else if (busy_q) begin
      rem_d = qbit ? SizeBits'(trial - {1'b0, den_q}) : trial[SizeBits-1:0];
      num_d = {num_q[DivBits-2:0], 1'b0};
      quo_d = {quo_q[DivBits-2:0], qbit};
      cnt_d = cnt_q - DivCntBits'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign step_o = quo_q[DivBits-1] ? {AccBits{1'b1}} : quo_q[AccBits-1:0];

endmodule

@@ rtl/core/nnis_front.sv @@
module nnis_front
  import nnis_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [PixelBits-1:0] s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  output logic                 head_valid_o,
  output item_t                head_o,
  input  logic                 pop_i
);

  item_t      buf_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       push;

  assign s_axis_tready_o = count_q != 2'd2;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign head_valid_o    = count_q != 2'd0;
  assign head_o          = buf_q[rptr_q];

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop_i ? ~rptr_q : rptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= '{fetch: s_axis_tuser_i, pixel: s_axis_tdata_i};
    end
  end

endmodule

@@ rtl/core/nnis_back.sv @@
module nnis_back
  import nnis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [SizeBits-1:0]   cfg_data_i,
  input  logic                  head_valid_i,
  input  item_t                 head_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [39:0]           m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  logic [SizeBits-1:0]  src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [SizeBits-1:0]  sw, sh, dw, dh;
  state_e               state_q, state_d;
  logic [AddrBits-1:0]  idx_q, idx_d;
  logic [AccBits-1:0]   step_x_q, step_x_d, step_y_q, step_y_d;
  logic [AccBits-1:0]   acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [CoordBits-1:0] col_q, col_d, row_q, row_d;
  logic [AddrBits-1:0]  addr_q, addr_d;
  logic                 out_valid_q, out_valid_d;
  logic [39:0]          out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;

  logic [2*SizeBits-1:0] total, idx_eff, idx_nxt, prod;
  logic [SizeBits-1:0]   sx, sy, col_n, row_n;
  logic                  first, ram_we, ram_re, div_start, out_take, last;
  logic                  div_done_x, div_done_y;
  logic [AccBits-1:0]    div_x, div_y;
  logic [PixelBits-1:0]  ram_rdata;

  assign sw = clamp_size(src_w_q, MaxWidthSz);
  assign sh = clamp_size(src_h_q, MaxHeightSz);
  assign dw = clamp_size(dst_w_q, MaxWidthSz);
  assign dh = clamp_size(dst_h_q, MaxHeightSz);

  assign total   = sw * sh;
  assign idx_eff = ({{(2*SizeBits-AddrBits){1'b0}}, idx_q} >= total) ? '0
                 : {{(2*SizeBits-AddrBits){1'b0}}, idx_q};
  assign idx_nxt = idx_eff + (2*SizeBits)'(1);

  always_comb begin
    sx = {1'b0, acc_x_q[AccBits-1:FracBits]};
    sy = {1'b0, acc_y_q[AccBits-1:FracBits]};
    if (sx >= sw) begin
      sx = sw - SizeBits'(1);
    end
    if (sy >= sh) begin
      sy = sh - SizeBits'(1);
    end
  end

  assign prod  = sy * sw + {{SizeBits{1'b0}}, sx};
  assign first = (col_q == '0) && (row_q == '0);
  assign col_n = {1'b0, col_q} + SizeBits'(1);
  assign row_n = {1'b0, row_q} + SizeBits'(1);
  assign last  = (col_n >= dw) && (row_n >= dh);

  assign pop_o     = (state_q == StIdle) && head_valid_i;
  assign ram_we    = pop_o && !head_i.fetch;
  assign div_start = pop_o && head_i.fetch && first;
  assign ram_re    = state_q == StRead;
  assign out_take  = (state_q == StOut) && (!out_valid_q || m_axis_tready_i);

  nnis_div u_div_x (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .src_i   (sw),
    .dst_i   (dw),
    .done_o  (div_done_x),
    .step_o  (div_x)
  );

  nnis_div u_div_y (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .src_i   (sh),
    .dst_i   (dh),
    .done_o  (div_done_y),
    .step_o  (div_y)
  );

  nnis_ram #(
    .Width (PixelBits),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (idx_eff[AddrBits-1:0]),
    .wdata_i (head_i.pixel),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    col_d       = col_q;
    row_d       = row_q;
    addr_d      = addr_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      StIdle: begin
        if (ram_we) begin
          idx_d = (idx_nxt >= total) ? '0 : idx_nxt[AddrBits-1:0];
        end
        if (pop_o && head_i.fetch) begin
          addr_d = prod[AddrBits-1:0];
          if (first) begin
            acc_x_d = '0;
            acc_y_d = '0;
            addr_d  = '0;
            state_d = StDiv;
          end else begin
            state_d = StRead;
          end
        end
      end
      StDiv: begin
        if (div_done_x && div_done_y) begin
          step_x_d = div_x;
          step_y_d = div_y;
          state_d  = StRead;
        end
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_take) begin
          out_valid_d = 1'b1;
          out_data_d  = {row_q, col_q, ram_rdata};
          out_last_d  = last;
          row_d       = row_n[CoordBits-1:0];
          acc_y_d     = acc_y_q + step_y_q;
          if (row_n >= dh) begin
            row_d   = '0;
            acc_y_d = '0;
            col_d   = col_n[CoordBits-1:0];
            acc_x_d = acc_x_q + step_x_q;
            if (col_n >= dw) begin
              col_d   = '0;
              acc_x_d = '0;
            end
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= SizeBits'(1);
      src_h_q     <= SizeBits'(1);
      dst_w_q     <= SizeBits'(1);
      dst_h_q     <= SizeBits'(1);
      state_q     <= StIdle;
      idx_q       <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSrcWidth:  src_w_q <= cfg_data_i;
          CfgSrcHeight: src_h_q <= cfg_data_i;
          CfgDstWidth:  dst_w_q <= cfg_data_i;
          CfgDstHeight: dst_h_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      idx_q       <= idx_d;
      step_x_q    <= step_x_d;
      step_y_q    <= step_y_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ rtl/core/nearest_neighbor_image_scaler_core.sv @@
// Nearest neighbor image scaler. Load items (tuser low) write source pixels in raster order
// into a 65536-entry pixel store; fetch items (tuser high) return the next destination pixel,
// column by column, sampled through 8.16 fixed-point accumulators. Items pass a two-entry
// queue into a sequencer that takes one item at a time. A load writes the store when popped.
// A fetch passes address multiply, registered store read and capture into the output register.
// The first fetch of each destination image also runs the two step divisions in parallel at
// one quotient bit per cycle. Results wait in an output register, so the next item can start
// while one is still untaken. The store is not cleared after reset.
module nearest_neighbor_image_scaler_core
  import nnis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [SizeBits-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PixelBits-1:0]  s_axis_tdata_i,  // pixel_in
  input  logic                  s_axis_tuser_i,  // func
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [39:0]           m_axis_tdata_o,  // pixel_out, dest_x, dest_y
  output logic                  m_axis_tlast_o   // last_pixel
);

  logic  head_valid;
  item_t head;
  logic  pop;

  nnis_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  nnis_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

endmodule

@@ tb/sv/nearest_neighbor_image_scaler_core_tb.sv @@
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_core_tb;
  import nnis_pkg::*;

  typedef struct packed {
    logic [PixelBits-1:0] pixel;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic                 last;
  } pixel_result_t;

  typedef enum logic [1:0] {
    OpLoad,
    OpFetch,
    OpCfg
  } stim_op_e;

  typedef struct packed {
    stim_op_e              op;
    logic [CfgIdxBits-1:0] reg_idx;
    logic [SizeBits-1:0]   reg_val;
    logic [PixelBits-1:0]  pix;
    logic                  typed;
    pixel_result_t         want;
  } dir_row_t;

  localparam int NumDirRows   = 25;
  localparam int NumEdgeCfgs  = 3;
  localparam int RandomItems  = 1850;
  localparam int SettleCycles = 48;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{OpLoad,  CfgSrcWidth,  9'd0, 24'hFFFFFF, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b1, '{24'hFFFFFF, 8'd0, 8'd0, 1'b1}},
    '{OpLoad,  CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'hFFFFFF, 1'b1, '{24'h000000, 8'd0, 8'd0, 1'b1}},
    '{OpCfg,   CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpCfg,   CfgSrcHeight, 9'd2, 24'h000000, 1'b0, '0},
    '{OpCfg,   CfgDstWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpCfg,   CfgDstHeight, 9'd4, 24'h000000, 1'b0, '0},
    '{OpLoad,  CfgSrcWidth,  9'd0, 24'h123456, 1'b0, '0},
    '{OpLoad,  CfgSrcWidth,  9'd0, 24'hFEDCBA, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b1, '{24'h123456, 8'd0, 8'd0, 1'b0}},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b1, '{24'h123456, 8'd0, 8'd1, 1'b0}},
    '{OpCfg,   CfgDstHeight, 9'd1, 24'h000000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpCfg,   CfgSrcWidth,  9'd2, 24'h000000, 1'b0, '0},
    '{OpCfg,   CfgSrcHeight, 9'd1, 24'h000000, 1'b0, '0},
    '{OpCfg,   CfgDstWidth,  9'd5, 24'h000000, 1'b0, '0},
    '{OpLoad,  CfgSrcWidth,  9'd0, 24'h000001, 1'b0, '0},
    '{OpLoad,  CfgSrcWidth,  9'd0, 24'h800000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0},
    '{OpFetch, CfgSrcWidth,  9'd0, 24'h000000, 1'b0, '0}
  };

  // Source width, source height, destination width, destination height.
  localparam logic [SizeBits-1:0] EdgeCfgs [NumEdgeCfgs][4] = '{
    '{9'd300, 9'd1,   9'd1,   9'd0},
    '{9'd3,   9'd2,   9'd511, 9'd1},
    '{9'd0,   9'd256, 9'd1,   9'd257}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [SizeBits-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [PixelBits-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [39:0]           m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  logic [SizeBits-1:0]  size_reg [4];
  logic [PixelBits-1:0] pix_store [StoreDepth];
  bit                   written [StoreDepth];
  int unsigned          load_ptr = 0;
  int unsigned          out_col = 0;
  int unsigned          out_row = 0;
  logic [AccBits-1:0]   step_x = '0;
  logic [AccBits-1:0]   step_y = '0;
  logic [AccBits-1:0]   acc_x = '0;
  logic [AccBits-1:0]   acc_y = '0;

  pixel_result_t pending_pixels [$];
  bit            failed = 1'b0;
  bit            no_gaps = 1'b0;
  int unsigned   n_items = 0;

  nearest_neighbor_image_scaler_core u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_dim(input logic [SizeBits-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic logic [AccBits-1:0] ratio_step(input int unsigned src, input int unsigned dst);
    longint unsigned q;
    q = (longint'(src) << FracBits) / dst;
    return (q > 64'hFFFFFF) ? '1 : q[AccBits-1:0];
  endfunction

  function automatic int unsigned next_read_addr();
    int unsigned sw, sh, sx, sy;
    sw = eff_dim(size_reg[CfgSrcWidth], MaxWidth);
    sh = eff_dim(size_reg[CfgSrcHeight], MaxHeight);
    if (out_col == 0 && out_row == 0) return 0;
    sx = 32'(acc_x[AccBits-1:FracBits]);
    sy = 32'(acc_y[AccBits-1:FracBits]);
    if (sx >= sw) sx = sw - 1;
    if (sy >= sh) sy = sh - 1;
    return sy * sw + sx;
  endfunction

  function automatic bit scale_pixel(input bit is_fetch, input logic [PixelBits-1:0] pix,
                                     output pixel_result_t res);
    int unsigned sw, sh, dw, dh, sx, sy, total;
    sw = eff_dim(size_reg[CfgSrcWidth], MaxWidth);
    sh = eff_dim(size_reg[CfgSrcHeight], MaxHeight);
    dw = eff_dim(size_reg[CfgDstWidth], MaxWidth);
    dh = eff_dim(size_reg[CfgDstHeight], MaxHeight);
    res = '0;
    if (!is_fetch) begin
      total = sw * sh;
      if (load_ptr >= total) load_ptr = 0;
      pix_store[load_ptr] = pix;
      written[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= total) load_ptr = 0;
      return 1'b0;
    end
    if (out_col == 0 && out_row == 0) begin
      step_x = ratio_step(sw, dw);
      step_y = ratio_step(sh, dh);
      acc_x = '0;
      acc_y = '0;
    end
    sx = 32'(acc_x[AccBits-1:FracBits]);
    sy = 32'(acc_y[AccBits-1:FracBits]);
    if (sx >= sw) sx = sw - 1;
    if (sy >= sh) sy = sh - 1;
    res.pixel = pix_store[sy * sw + sx];
    res.x = out_col[CoordBits-1:0];
    res.y = out_row[CoordBits-1:0];
    res.last = (out_col + 1 >= dw) && (out_row + 1 >= dh);
    out_row++;
    acc_y = acc_y + step_y;
    if (out_row >= dh) begin
      out_row = 0;
      acc_y = '0;
      out_col++;
      acc_x = acc_x + step_x;
      if (out_col >= dw) begin
        out_col = 0;
        acc_x = '0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [PixelBits-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PixelBits'($urandom());
    endcase
  endfunction

  task automatic send_item(input bit is_fetch, input logic [PixelBits-1:0] pix, input bit typed,
                           input pixel_result_t want);
    int unsigned   gap;
    pixel_result_t res;
    bit            produced;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = is_fetch;
    s_axis_tdata_i = pix;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    produced = scale_pixel(is_fetch, pix, res);
    if (produced) pending_pixels.push_back(typed ? want : res);
    n_items++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [SizeBits-1:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    size_reg[idx] = val;
  endtask

  task automatic write_sizes(input logic [SizeBits-1:0] sw, input logic [SizeBits-1:0] sh,
                             input logic [SizeBits-1:0] dw, input logic [SizeBits-1:0] dh);
    wait_idle();
    write_reg(CfgSrcWidth, sw);
    write_reg(CfgSrcHeight, sh);
    write_reg(CfgDstWidth, dw);
    write_reg(CfgDstHeight, dh);
  endtask

  initial begin
    int unsigned stall;
    @(negedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 18);
      m_axis_tready_i = 1'b0;
      repeat (stall) @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    pixel_result_t want;
    logic [PixelBits-1:0] got_pixel;
    logic [CoordBits-1:0] got_x, got_y;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_pixel = m_axis_tdata_o[PixelBits-1:0];
      got_x = m_axis_tdata_o[PixelBits+CoordBits-1:PixelBits];
      got_y = m_axis_tdata_o[PixelBits+2*CoordBits-1:PixelBits+CoordBits];
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result: expected none, got %06h (%0d,%0d) last %b", $time,
                 got_pixel, got_x, got_y, m_axis_tlast_o);
        failed = 1'b1;
      end else begin
        want = pending_pixels.pop_front();
        if (got_pixel !== want.pixel) begin
          $display("%0t pixel_out: expected %06h, got %06h", $time, want.pixel, got_pixel);
          failed = 1'b1;
        end
        if (got_x !== want.x) begin
          $display("%0t dest_x: expected %0d, got %0d", $time, want.x, got_x);
          failed = 1'b1;
        end
        if (got_y !== want.y) begin
          $display("%0t dest_y: expected %0d, got %0d", $time, want.y, got_y);
          failed = 1'b1;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t last_pixel: expected %b, got %b", $time, want.last, m_axis_tlast_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned phase, n_load, n_fetch, img, sw, sh, k, pick;
    bit          prev_cfg, resized;
    foreach (size_reg[i]) size_reg[i] = SizeBits'(1);
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    prev_cfg = 1'b0;
    foreach (DirRows[i]) begin
      if (DirRows[i].op == OpCfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(DirRows[i].reg_idx, DirRows[i].reg_val);
        prev_cfg = 1'b1;
      end else begin
        send_item(DirRows[i].op == OpFetch, DirRows[i].pix, DirRows[i].typed, DirRows[i].want);
        prev_cfg = 1'b0;
      end
    end

    n_items = 0;
    phase = 0;
    while (n_items < RandomItems) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      resized = 1'b1;
      if (phase < NumEdgeCfgs) begin
        write_sizes(EdgeCfgs[phase][0], EdgeCfgs[phase][1], EdgeCfgs[phase][2],
                    EdgeCfgs[phase][3]);
      end else if ($urandom_range(0, 4) != 0) begin
        write_sizes(SizeBits'($urandom_range(0, 10)), SizeBits'($urandom_range(0, 10)),
                    SizeBits'($urandom_range(0, 12)), SizeBits'($urandom_range(0, 12)));
      end else begin
        resized = 1'b0;
      end
      sw = eff_dim(size_reg[CfgSrcWidth], MaxWidth);
      sh = eff_dim(size_reg[CfgSrcHeight], MaxHeight);
      img = eff_dim(size_reg[CfgDstWidth], MaxWidth) * eff_dim(size_reg[CfgDstHeight], MaxHeight);
      if (resized) begin
        n_load = sw * sh;
        if (phase >= NumEdgeCfgs && $urandom_range(0, 5) == 0) n_load = $urandom_range(1, n_load);
      end else begin
        n_load = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      end
      for (k = 0; k < n_load; k++) send_item(1'b0, rand_pixel(), 1'b0, '0);
      if (phase < NumEdgeCfgs) begin
        n_fetch = (img == 1) ? 3 : img;
      end else begin
        pick = $urandom_range(0, 3);
        if (pick == 0) n_fetch = $urandom_range(1, img);
        else if (pick == 3) n_fetch = img + $urandom_range(1, img);
        else n_fetch = img;
      end
      k = 0;
      while (k < n_fetch) begin
        if ($urandom_range(0, 9) == 0 || !written[next_read_addr()]) begin
          send_item(1'b0, rand_pixel(), 1'b0, '0);
        end else begin
          send_item(1'b1, rand_pixel(), 1'b0, '0);
          k++;
        end
      end
      phase++;
    end

    wait_idle();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
